// ===== rtl/prts_pkg.sv =====
// Shared constants, command codes and a helper function of the telemetry scheduler.
package prts_pkg;

  localparam int NUM_LEVELS_DEF   = 5;
  localparam int NUM_MESSAGES_DEF = 9;
  localparam int MAX_LEVELS       = 8;
  localparam int MAX_MESSAGES     = 16;
  localparam int CONFIG_COUNT     = 5;

  localparam int CMD_W      = 2;
  localparam int MSG_ID_W   = 4;
  localparam int LEVEL_W    = 3;
  localparam int TIME_W     = 32;
  localparam int SPACE_W    = 16;
  localparam int INTERVAL_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic [SPACE_W-1:0] SPACE_WIFI = 16'd20;
  localparam logic [SPACE_W-1:0] SPACE_USB  = 16'd60;
  localparam int INTERVAL_RATIO = 5;

  localparam logic [CMD_W-1:0] CMD_TICK        = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SUBSCRIBE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNSUBSCRIBE = 2'd2;

  typedef logic [INTERVAL_W-1:0] interval_t;
  typedef logic [TIME_W-1:0]     time_t;

  // Reset interval of a level: the ratio raised to the level, saturated to 16 bits.
  function automatic interval_t reset_interval(input int lvl);
    int v;
    v = 1;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (i < lvl) begin
        v = v * INTERVAL_RATIO;
        if (v > 65535) begin
          v = 65535;
        end
      end
    end
    return interval_t'(v);
  endfunction

endpackage

// ===== rtl/prts_due_unit.sv =====
// Shared elapsed-time unit: decides whether the level under scan is due to send.
module prts_due_unit (
  input  logic                   mask_any,
  input  prts_pkg::time_t        time_now,
  input  prts_pkg::time_t        last_time,
  input  prts_pkg::interval_t    interval,
  output logic                   due
);

  prts_pkg::time_t elapsed;

  // The difference wraps modulo 2^32, as the tick counter does.
  assign elapsed = time_now - last_time;
  assign due     = mask_any && (elapsed > {{(prts_pkg::TIME_W - prts_pkg::INTERVAL_W){1'b0}},
                                           interval});

endmodule

// ===== rtl/priority_round_robin_telemetry_scheduler_top.sv =====
// Top level of the strict-priority, round-robin telemetry scheduler.
//
// Every input transfer yields exactly one result transfer. Subscribe, unsubscribe, the unused
// command and a tick without room finish in the accepting cycle and present their result on
// the next one. A tick with room walks the levels one per cycle through a single shared
// elapsed-time comparator, then steps the round-robin pointer of the chosen level one
// message per cycle; the block takes the next item in the cycle after the result transfer.
// The configuration port never stalls, but an interval register must only be written
// while no item is in flight.
module priority_round_robin_telemetry_scheduler_top #(
  parameter int NUM_LEVELS   = prts_pkg::NUM_LEVELS_DEF,
  parameter int NUM_MESSAGES = prts_pkg::NUM_MESSAGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [prts_pkg::CMD_W-1:0]      in_command,
  input  logic [prts_pkg::MSG_ID_W-1:0]   in_message_id,
  input  logic [prts_pkg::LEVEL_W-1:0]    in_level,
  input  logic [prts_pkg::TIME_W-1:0]     in_time_now,
  input  logic                            in_via_wifi,
  input  logic [prts_pkg::SPACE_W-1:0]    in_free_space,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_send_valid,
  output logic [prts_pkg::MSG_ID_W-1:0]   out_send_message,
  output logic [prts_pkg::LEVEL_W-1:0]    out_send_level,
  output logic                            out_accepted,

  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [prts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prts_pkg::INTERVAL_W-1:0] cfg_data
);

  localparam int LVL_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int MSG_W = (NUM_MESSAGES > 1) ? $clog2(NUM_MESSAGES) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_PICK = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;

  logic [NUM_MESSAGES-1:0] mask_r      [NUM_LEVELS];
  prts_pkg::time_t         last_time_r [NUM_LEVELS];
  logic [MSG_W-1:0]        last_msg_r  [NUM_LEVELS];
  prts_pkg::interval_t     interval_r  [NUM_LEVELS];

  prts_pkg::time_t  time_r;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  logic [MSG_W-1:0] ptr_r, ptr_nxt;

  logic                          res_send_r, res_send_nxt;
  logic [prts_pkg::MSG_ID_W-1:0] res_msg_r, res_msg_nxt;
  logic [prts_pkg::LEVEL_W-1:0]  res_lvl_r, res_lvl_nxt;
  logic                          res_acc_r, res_acc_nxt;

  logic in_take;
  logic space_ok;
  logic msg_ok;
  logic lvl_ok;
  logic do_sub;
  logic do_unsub;
  logic due;
  logic hit;
  logic [MSG_W-1:0] ptr_next_last;
  logic [MSG_W-1:0] ptr_next_cur;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid        = (state_r == ST_OUT);
  assign out_send_valid   = res_send_r;
  assign out_send_message = res_msg_r;
  assign out_send_level   = res_lvl_r;
  assign out_accepted     = res_acc_r;

  assign space_ok = in_via_wifi ? (in_free_space > prts_pkg::SPACE_WIFI)
                                : (in_free_space > prts_pkg::SPACE_USB);
  assign msg_ok   = ({1'b0, in_message_id} < (prts_pkg::MSG_ID_W + 1)'(NUM_MESSAGES));
  assign lvl_ok   = ({1'b0, in_level} < (prts_pkg::LEVEL_W + 1)'(NUM_LEVELS));
  assign do_sub   = in_take && (in_command == prts_pkg::CMD_SUBSCRIBE) && msg_ok && lvl_ok;
  assign do_unsub = in_take && (in_command == prts_pkg::CMD_UNSUBSCRIBE) && msg_ok;

  prts_due_unit u_due (
    .mask_any  (|mask_r[lvl_r]),
    .time_now  (time_r),
    .last_time (last_time_r[lvl_r]),
    .interval  (interval_r[lvl_r]),
    .due       (due)
  );

  assign ptr_next_last = (last_msg_r[lvl_r] == MSG_W'(NUM_MESSAGES - 1)) ? '0
                                                                           : last_msg_r[lvl_r] + 1'b1;
  assign ptr_next_cur  = (ptr_r == MSG_W'(NUM_MESSAGES - 1)) ? '0 : ptr_r + 1'b1;
  assign hit           = (state_r == ST_PICK) && mask_r[lvl_r][ptr_r];

  always_comb begin
    state_nxt    = state_r;
    lvl_nxt      = lvl_r;
    ptr_nxt      = ptr_r;
    res_send_nxt = res_send_r;
    res_msg_nxt  = res_msg_r;
    res_lvl_nxt  = res_lvl_r;
    res_acc_nxt  = res_acc_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          res_send_nxt = 1'b0;
          res_msg_nxt  = '0;
          res_lvl_nxt  = '0;
          res_acc_nxt  = do_sub || do_unsub;
          lvl_nxt      = '0;
          if ((in_command == prts_pkg::CMD_TICK) && space_ok) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_SCAN: begin
        if (due) begin
          ptr_nxt   = ptr_next_last;
          state_nxt = ST_PICK;
        end else if (lvl_r == LVL_W'(NUM_LEVELS - 1)) begin
          state_nxt = ST_OUT;
        end else begin
          lvl_nxt = lvl_r + 1'b1;
        end
      end
      ST_PICK: begin
        if (hit) begin
          res_send_nxt = 1'b1;
          res_msg_nxt  = prts_pkg::MSG_ID_W'(ptr_r);
          res_lvl_nxt  = prts_pkg::LEVEL_W'(lvl_r);
          state_nxt    = ST_OUT;
        end else begin
          ptr_nxt = ptr_next_cur;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r      <= lvl_nxt;
    ptr_r      <= ptr_nxt;
    res_send_r <= res_send_nxt;
    res_msg_r  <= res_msg_nxt;
    res_lvl_r  <= res_lvl_nxt;
    res_acc_r  <= res_acc_nxt;
    if (in_take) begin
      time_r <= in_time_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        mask_r[i]      <= '0;
        last_time_r[i] <= '0;
        last_msg_r[i]  <= '0;
        interval_r[i]  <= prts_pkg::reset_interval(i);
      end
    end else begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        for (int j = 0; j < NUM_MESSAGES; j++) begin
          if ((do_sub || do_unsub) && (in_message_id == prts_pkg::MSG_ID_W'(j))) begin
            mask_r[i][j] <= do_sub && (in_level == prts_pkg::LEVEL_W'(i));
          end
        end
        if (hit && (lvl_r == LVL_W'(i))) begin
          last_time_r[i] <= time_r;
          last_msg_r[i]  <= ptr_r;
        end
        if (cfg_valid && cfg_ready && (i < prts_pkg::CONFIG_COUNT) &&
            (cfg_index == prts_pkg::CFG_IDX_W'(i))) begin
          interval_r[i] <= cfg_data;
        end
      end
    end
  end

endmodule

// ===== test/tb_priority_round_robin_telemetry_scheduler_top.sv =====
// Self-checking testbench of the telemetry scheduler, with directed and random requests.
module tb_priority_round_robin_telemetry_scheduler_top;
  import prts_pkg::*;

  localparam int LEVELS       = NUM_LEVELS_DEF;
  localparam int MESSAGES     = NUM_MESSAGES_DEF;
  localparam int TICK_LATENCY = 1 + LEVELS + MESSAGES;
  localparam int HOLD_LEN     = 400;
  localparam int REPORT_LIMIT = 10;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [MSG_ID_W-1:0] message_id;
    logic [LEVEL_W-1:0]  level;
    time_t               time_now;
    logic                via_wifi;
    logic [SPACE_W-1:0]  free_space;
  } request_t;

  typedef struct packed {
    logic                send_valid;
    logic [MSG_ID_W-1:0] send_message;
    logic [LEVEL_W-1:0]  send_level;
    logic                accepted;
  } send_result_t;

  class schedule_scoreboard;
    interval_t           lvl_interval [LEVELS];
    logic [MESSAGES-1:0] sub_mask [LEVELS];
    time_t               last_time [LEVELS];
    int                  last_msg [LEVELS];
    send_result_t        expected_sends [$];
    int                  failures;

    function new();
      int v;
      v = 1;
      failures = 0;
      for (int p = 0; p < LEVELS; p++) begin
        lvl_interval[p] = interval_t'(v);
        v = v * INTERVAL_RATIO;
        if (v > 65535) begin
          v = 65535;
        end
        sub_mask[p]  = '0;
        last_time[p] = '0;
        last_msg[p]  = 0;
      end
    endfunction

    function void note_request(request_t r);
      send_result_t res;
      logic         room;
      time_t        age;
      int           f;
      res = '0;
      case (r.command)
        CMD_TICK: begin
          room = r.via_wifi ? (r.free_space > SPACE_WIFI) : (r.free_space > SPACE_USB);
          for (int p = 0; p < LEVELS; p++) begin
            age = r.time_now - last_time[p];
            if (room && !res.send_valid && sub_mask[p] != '0 &&
                age > time_t'(lvl_interval[p])) begin
              f = last_msg[p] % MESSAGES;
              for (int k = 0; k < MESSAGES; k++) begin
                f = (f + 1) % MESSAGES;
                if (sub_mask[p][f] && !res.send_valid) begin
                  res.send_valid   = 1'b1;
                  res.send_message = MSG_ID_W'(f);
                  res.send_level   = LEVEL_W'(p);
                  last_msg[p]      = f;
                  last_time[p]     = r.time_now;
                end
              end
            end
          end
        end
        CMD_SUBSCRIBE: begin
          if (r.message_id < MESSAGES && r.level < LEVELS) begin
            for (int p = 0; p < LEVELS; p++) begin
              sub_mask[p][r.message_id] = 1'b0;
            end
            sub_mask[r.level][r.message_id] = 1'b1;
            res.accepted = 1'b1;
          end
        end
        CMD_UNSUBSCRIBE: begin
          if (r.message_id < MESSAGES) begin
            for (int p = 0; p < LEVELS; p++) begin
              sub_mask[p][r.message_id] = 1'b0;
            end
            res.accepted = 1'b1;
          end
        end
        default: begin
          res = '0;
        end
      endcase
      expected_sends.push_back(res);
    endfunction

    function void check_send(send_result_t got);
      send_result_t want;
      if (expected_sends.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("Result with nothing expected: valid=%0d msg=%0d lvl=%0d acc=%0d",
                   got.send_valid, got.send_message, got.send_level, got.accepted);
        end
      end else begin
        want = expected_sends.pop_front();
        if (got.send_valid !== want.send_valid || got.send_message !== want.send_message ||
            got.send_level !== want.send_level || got.accepted !== want.accepted) begin
          failures++;
          if (failures <= REPORT_LIMIT) begin
            $display("Mismatch: expected valid=%0d msg=%0d lvl=%0d acc=%0d, %s%0d %s%0d %s%0d %s%0d",
                     want.send_valid, want.send_message, want.send_level, want.accepted,
                     "got valid=", got.send_valid, "msg=", got.send_message,
                     "lvl=", got.send_level, "acc=", got.accepted);
          end
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_command = CMD_TICK;
  logic [MSG_ID_W-1:0]   in_message_id = '0;
  logic [LEVEL_W-1:0]    in_level = '0;
  logic [TIME_W-1:0]     in_time_now = '0;
  logic                  in_via_wifi = 1'b0;
  logic [SPACE_W-1:0]    in_free_space = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_send_valid;
  logic [MSG_ID_W-1:0]   out_send_message;
  logic [LEVEL_W-1:0]    out_send_level;
  logic                  out_accepted;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [INTERVAL_W-1:0] cfg_data = '0;

  schedule_scoreboard board;
  send_result_t       seen;
  time_t              now_ms = '0;
  int                 snd_idle_pct = 0;
  int                 rcv_idle_pct = 0;
  logic               pressure_on = 1'b0;
  int                 hold_cycles = 0;

  priority_round_robin_telemetry_scheduler_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_message_id    (in_message_id),
    .in_level         (in_level),
    .in_time_now      (in_time_now),
    .in_via_wifi      (in_via_wifi),
    .in_free_space    (in_free_space),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_send_valid   (out_send_valid),
    .out_send_message (out_send_message),
    .out_send_level   (out_send_level),
    .out_accepted     (out_accepted),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The receiver stalls at random, or holds off for a long stretch when pressure is on.
  always @(posedge clk) begin
    if (pressure_on && hold_cycles < HOLD_LEN) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen = {out_send_valid, out_send_message, out_send_level, out_accepted};
      board.check_send(seen);
    end
  end

  function automatic request_t mk(logic [CMD_W-1:0] c, int m, int l, time_t t, logic w, int s);
    request_t r;
    r.command    = c;
    r.message_id = MSG_ID_W'(m);
    r.level      = LEVEL_W'(l);
    r.time_now   = t;
    r.via_wifi   = w;
    r.free_space = SPACE_W'(s);
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      r.command = CMD_TICK;
    end else if (pick < 82) begin
      r.command = CMD_SUBSCRIBE;
    end else if (pick < 94) begin
      r.command = CMD_UNSUBSCRIBE;
    end else begin
      r.command = CMD_UNUSED;
    end
    r.message_id = ($urandom_range(99) < 85) ? MSG_ID_W'($urandom_range(MESSAGES - 1))
                                             : MSG_ID_W'($urandom_range(15, MESSAGES));
    r.level = ($urandom_range(99) < 85) ? LEVEL_W'($urandom_range(LEVELS - 1))
                                        : LEVEL_W'($urandom_range(7, LEVELS));
    pick = $urandom_range(99);
    if (pick < 2) begin
      now_ms = $urandom();
    end else if (pick < 10) begin
      now_ms = now_ms + $urandom_range(3000);
    end else begin
      now_ms = now_ms + $urandom_range(40);
    end
    r.time_now = now_ms;
    r.via_wifi = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 70) begin
      r.free_space = SPACE_W'($urandom_range(65535, 61));
    end else if (pick < 85) begin
      r.free_space = SPACE_W'($urandom_range(66, 15));
    end else begin
      r.free_space = SPACE_W'($urandom());
    end
    return r;
  endfunction

  task automatic push_request(input request_t r);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid      <= 1'b1;
    in_command    <= r.command;
    in_message_id <= r.message_id;
    in_level      <= r.level;
    in_time_now   <= r.time_now;
    in_via_wifi   <= r.via_wifi;
    in_free_space <= r.free_space;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(r);
  endtask

  task automatic run_batch(input int count);
    for (int n = 0; n < count; n++) begin
      push_request(random_request());
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (board.expected_sends.size() != 0) @(posedge clk);
    repeat (TICK_LATENCY) @(posedge clk);
  endtask

  // Element i of vals goes to interval register i; one write to an unused index follows.
  task automatic configure(input logic [CONFIG_COUNT-1:0][INTERVAL_W-1:0] vals);
    for (int i = 0; i <= CONFIG_COUNT; i++) begin
      cfg_valid <= 1'b1;
      if (i < CONFIG_COUNT) begin
        cfg_index <= CFG_IDX_W'(i);
        cfg_data  <= vals[i];
      end else begin
        cfg_index <= CFG_IDX_W'($urandom_range(7, CONFIG_COUNT));
        cfg_data  <= INTERVAL_W'($urandom());
      end
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (i < CONFIG_COUNT) begin
        board.lvl_interval[i] = vals[i];
      end
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    #5000000;
    $display("tb_priority_round_robin_telemetry_scheduler_top: FAIL");
    $finish;
  end

  initial begin
    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests run against the reset intervals.
    push_request(mk(CMD_TICK, 0, 0, 100, 1'b0, 65535));
    push_request(mk(CMD_SUBSCRIBE, 15, 0, 0, 1'b0, 0));
    push_request(mk(CMD_SUBSCRIBE, 0, 7, 0, 1'b0, 0));
    push_request(mk(CMD_UNSUBSCRIBE, 9, 0, 0, 1'b0, 0));
    push_request(mk(CMD_UNUSED, 15, 7, 32'hFFFF_FFFF, 1'b1, 65535));
    push_request(mk(CMD_SUBSCRIBE, 8, 0, 0, 1'b0, 0));
    push_request(mk(CMD_SUBSCRIBE, 0, 0, 0, 1'b0, 0));
    push_request(mk(CMD_SUBSCRIBE, 3, 4, 0, 1'b0, 0));
    push_request(mk(CMD_TICK, 0, 0, 1, 1'b0, 60));
    push_request(mk(CMD_TICK, 0, 0, 1, 1'b1, 20));
    push_request(mk(CMD_TICK, 0, 0, 1, 1'b1, 21));
    push_request(mk(CMD_TICK, 0, 0, 2, 1'b0, 61));
    push_request(mk(CMD_TICK, 0, 0, 4, 1'b1, 65535));
    push_request(mk(CMD_SUBSCRIBE, 0, 1, 5, 1'b0, 0));
    push_request(mk(CMD_TICK, 0, 0, 32'hFFFF_FFF0, 1'b0, 1000));
    push_request(mk(CMD_TICK, 0, 0, 32'h0000_0005, 1'b1, 1000));
    push_request(mk(CMD_UNSUBSCRIBE, 8, 0, 0, 1'b0, 0));
    push_request(mk(CMD_TICK, 0, 0, 32'h0000_0010, 1'b0, 1000));
    push_request(mk(CMD_TICK, 0, 0, 32'hFFFF_FFFF, 1'b0, 0));
    push_request(mk(CMD_TICK, 15, 7, 32'h7FFF_FFFF, 1'b1, 32768));
    push_request(mk(CMD_SUBSCRIBE, 5, 4, 0, 1'b0, 0));
    push_request(mk(CMD_TICK, 0, 0, 32'hFFFF_FFFF, 1'b0, 65535));
    push_request(mk(CMD_UNSUBSCRIBE, 0, 0, 0, 1'b0, 0));
    push_request(mk(CMD_TICK, 0, 0, 32'hFFFF_FFFF, 1'b1, 65535));
    push_request(mk(CMD_UNSUBSCRIBE, 15, 7, 32'hFFFF_FFFF, 1'b1, 65535));
    in_valid <= 1'b0;
    drain();

    snd_idle_pct = 23;
    rcv_idle_pct <= 69;
    configure({16'd200, 16'd40, 16'd10, 16'd2, 16'd0});
    run_batch(350);
    drain();

    snd_idle_pct = 69;
    rcv_idle_pct <= 23;
    configure({16'd0, 16'd7, 16'hFFFF, 16'd0, 16'hFFFF});
    run_batch(350);
    drain();

    // The receiver holds off while requests keep coming, so the block backs up.
    snd_idle_pct = 0;
    rcv_idle_pct <= 0;
    configure({16'd3000, 16'd300, 16'd30, 16'd3, 16'd1});
    pressure_on <= 1'b1;
    run_batch(100);
    drain();
    pressure_on <= 1'b0;

    configure({16'hFFFF, 16'd3000, 16'd300, 16'd30, 16'd3});
    run_batch(500);
    drain();
    repeat (TICK_LATENCY) @(posedge clk);

    if (board.failures == 0 && board.expected_sends.size() == 0) begin
      $display("tb_priority_round_robin_telemetry_scheduler_top: PASS");
    end else begin
      $display("tb_priority_round_robin_telemetry_scheduler_top: FAIL");
    end
    $finish;
  end

endmodule
